>>> src/binary_tree_order_walker_top_assert.svh
// assertion macros for the binary tree order walker
// used by binary_tree_order_walker_top; needs nothing else
`ifndef BINARY_TREE_ORDER_WALKER_TOP_ASSERT_SVH
`define BINARY_TREE_ORDER_WALKER_TOP_ASSERT_SVH

// condition in the same cycle
`define BTOW_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("btow check failed");

// condition in the following cycle
`define BTOW_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("btow check failed");

`endif

>>> src/btow_pkg.sv
// types and constants of the binary tree order walker
// no dependencies
`timescale 1ns / 1ps

package btow_pkg;

    // request codes carried in the input tuser
    typedef logic [1:0] t_req;
    localparam t_req REQ_CLEAR    = 2'd0;
    localparam t_req REQ_LOAD     = 2'd1;
    localparam t_req REQ_TRAVERSE = 2'd2;

    // traversal order codes
    typedef logic [1:0] t_order;
    localparam t_order ORD_PRE  = 2'd0;
    localparam t_order ORD_IN   = 2'd1;
    localparam t_order ORD_POST = 2'd2;

    // field widths
    localparam int ID_W    = 5;
    localparam int CHILD_W = 6;
    localparam int COUNT_W = 6;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    // results per walk before it is cut off
    localparam int MAX_OUT = 32;

endpackage

>>> src/btow_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module btow_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> src/binary_tree_order_walker_top.sv
// Binary tree order walker. A word on the input stream either clears all parent
// marks, loads one node (its left and right child, -1 for none), or starts a
// traversal in pre-, in- or postorder from the lowest-numbered parentless node
// below the given count. A traversal returns one word per visited node, tlast on
// the final one; with no root it returns a single word with tuser (no_root) set.
// Clear and load are taken while idle and can follow back to back. A traversal
// first scans the parent marks one node a cycle, then walks with a stack held
// in memory: expanding a node takes a stack read, a child table read and up to
// three stack writes through the single write port, and emitting it takes a
// second pop and stack read. No new word is taken during a traversal; a
// finished result waits in the output register without blocking the input.
// needs btow_pkg, btow_ram and binary_tree_order_walker_top_assert.svh
`timescale 1ns / 1ps
`include "binary_tree_order_walker_top_assert.svh"

module binary_tree_order_walker_top
    import btow_pkg::*;
#(
    parameter int NODES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tdata: node_id[4:0], left_child[10:5], right_child[16:11],
    //        node_count[22:17], order[24:23], zero fill above
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: visited_node[4:0], order_done[6:5], zero fill above
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tlast,
    // tuser: no_root[0]
    output logic [0:0]           m_axis_tuser
);

    localparam int NW      = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW      = $clog2(NODES + 1);
    localparam int POP_LIM = 4 * NODES + 4;
    localparam int PW      = $clog2(POP_LIM + 1);
    localparam int KW      = $clog2(MAX_OUT + 1);
    localparam int EW      = NW + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SEARCH, ST_NOROOT, ST_POP, ST_STK, ST_TBL, ST_PUSH, ST_EMIT, ST_FIN
    } t_state;

    // stack entry: expanded flag over node id
    typedef struct packed {
        logic          expanded;
        logic [NW-1:0] node;
    } t_entry;

    // input word fields
    t_req                 in_req;
    logic [ID_W-1:0]      in_nid;
    logic [CHILD_W-1:0]   in_left;
    logic [CHILD_W-1:0]   in_right;
    logic [COUNT_W-1:0]   in_cnt;
    t_order               in_ord;
    logic                 in_acc;
    logic                 out_free;

    assign in_req   = s_axis_tuser;
    assign in_nid   = s_axis_tdata[4:0];
    assign in_left  = s_axis_tdata[10:5];
    assign in_right = s_axis_tdata[16:11];
    assign in_cnt   = s_axis_tdata[22:17];
    assign in_ord   = s_axis_tdata[24:23];

    t_state               r_state, n_state;
    t_order               r_ord, n_ord;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [CW-1:0]        r_idx, n_idx;
    logic [NW-1:0]        r_root, n_root;
    logic [CW-1:0]        r_sp, n_sp;
    logic [PW-1:0]        r_pops, n_pops;
    logic [KW-1:0]        r_k, n_k;
    logic [NW-1:0]        r_ent, n_ent;
    logic [2:0]           r_slot_v, n_slot_v;
    t_entry [2:0]         r_slot, n_slot;
    logic [1:0]           r_j, n_j;
    logic                 r_pend_v, n_pend_v;
    logic [NW-1:0]        r_pend, n_pend;
    logic [NODES-1:0]     r_hp, n_hp;
    logic                 r_m_valid, n_m_valid;
    logic [ID_W-1:0]      r_m_node, n_m_node;
    t_order               r_m_ord, n_m_ord;
    logic                 r_m_last, n_m_last;
    logic                 r_m_noroot, n_m_noroot;

    // memory ports
    logic                 tbl_we;
    logic [NW-1:0]        tbl_wa, tbl_ra;
    logic [2*CHILD_W-1:0] tbl_wd, tbl_rd;
    logic                 stk_we;
    logic [NW-1:0]        stk_wa, stk_ra;
    t_entry               stk_wd, stk_rd;

    // child decode helpers
    logic [6:0]           nid_x;
    logic                 ld_ok, ld_lv, ld_rv;
    logic [CHILD_W-1:0]   tb_left, tb_right;
    logic                 tb_lv, tb_rv;
    t_entry               e_self, e_left, e_right;
    logic [6:0]           cnt_x;
    logic [6:0]           node_x;

    btow_ram #(.WIDTH(2 * CHILD_W), .DEPTH(NODES)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_wa),
        .i_wdata (tbl_wd),
        .i_raddr (tbl_ra),
        .o_rdata (tbl_rd)
    );

    btow_ram #(.WIDTH(EW), .DEPTH(NODES)) u_stk (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_wa),
        .i_wdata (stk_wd),
        .i_raddr (stk_ra),
        .o_rdata (stk_rd)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    // load decode: children are nodes only when non-negative and below NODES
    assign nid_x  = 7'(in_nid);
    assign ld_ok  = nid_x < 7'(NODES);
    assign ld_lv  = !in_left[CHILD_W-1] && (7'(in_left) < 7'(NODES));
    assign ld_rv  = !in_right[CHILD_W-1] && (7'(in_right) < 7'(NODES));
    assign cnt_x  = 7'(in_cnt);

    // table read decode for expansion
    assign tb_left  = tbl_rd[CHILD_W-1:0];
    assign tb_right = tbl_rd[2*CHILD_W-1:CHILD_W];
    assign tb_lv    = !tb_left[CHILD_W-1] && (7'(tb_left) < 7'(NODES));
    assign tb_rv    = !tb_right[CHILD_W-1] && (7'(tb_right) < 7'(NODES));
    assign e_self   = '{expanded: 1'b1, node: r_ent};
    assign e_left   = '{expanded: 1'b0, node: tb_left[NW-1:0]};
    assign e_right  = '{expanded: 1'b0, node: tb_right[NW-1:0]};

    // table write from loads, reads follow the popped stack entry
    assign tbl_we = in_acc && (in_req == REQ_LOAD) && ld_ok;
    assign tbl_wa = nid_x[NW-1:0];
    assign tbl_wd = {in_right, in_left};
    assign tbl_ra = stk_rd.node;
    assign stk_ra = NW'(r_sp - CW'(1));

    // next state and datapath
    always_comb begin
        n_state    = r_state;
        n_ord      = r_ord;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_root     = r_root;
        n_sp       = r_sp;
        n_pops     = r_pops;
        n_k        = r_k;
        n_ent      = r_ent;
        n_slot_v   = r_slot_v;
        n_slot     = r_slot;
        n_j        = r_j;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_hp       = r_hp;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_node   = r_m_node;
        n_m_ord    = r_m_ord;
        n_m_last   = r_m_last;
        n_m_noroot = r_m_noroot;
        stk_we     = 1'b0;
        stk_wa     = r_sp[NW-1:0];
        stk_wd     = r_slot[r_j];
        node_x     = 7'(r_pend);

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_req)
                        REQ_CLEAR: begin
                            n_hp = '0;
                        end
                        REQ_LOAD: begin
                            if (ld_ok && ld_lv) n_hp[in_left[NW-1:0]] = 1'b1;
                            if (ld_ok && ld_rv) n_hp[in_right[NW-1:0]] = 1'b1;
                        end
                        REQ_TRAVERSE: begin
                            n_ord   = (in_ord == 2'd3) ? ORD_PRE : in_ord;
                            n_cnt   = (cnt_x > 7'(NODES)) ? CW'(NODES) : CW'(cnt_x);
                            n_idx   = '0;
                            n_state = ST_SEARCH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // scan parent marks one node a cycle
            ST_SEARCH: begin
                if (r_idx >= r_cnt) begin
                    n_state = ST_NOROOT;
                end else if (!r_hp[r_idx[NW-1:0]]) begin
                    n_root   = r_idx[NW-1:0];
                    stk_we   = 1'b1;
                    stk_wa   = '0;
                    stk_wd   = '{expanded: 1'b0, node: r_idx[NW-1:0]};
                    n_sp     = CW'(1);
                    n_pops   = '0;
                    n_k      = '0;
                    n_pend_v = 1'b0;
                    n_state  = ST_POP;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            ST_NOROOT: begin
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_node   = '0;
                    n_m_ord    = r_ord;
                    n_m_last   = 1'b1;
                    n_m_noroot = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            // pop the top entry, its read address is r_sp - 1
            ST_POP: begin
                if ((r_sp != '0) && (r_k < KW'(MAX_OUT)) && (r_pops < PW'(POP_LIM))) begin
                    n_sp    = r_sp - CW'(1);
                    n_pops  = r_pops + PW'(1);
                    n_state = ST_STK;
                end else begin
                    n_state = ST_FIN;
                end
            end
            // stack data is here; child table read issued on its node
            ST_STK: begin
                n_ent   = stk_rd.node;
                n_state = stk_rd.expanded ? ST_EMIT : ST_TBL;
            end
            // children are here: order the pushes
            ST_TBL: begin
                unique case (r_ord)
                    ORD_IN: begin
                        n_slot   = {e_left, e_self, e_right};
                        n_slot_v = {tb_lv, 1'b1, tb_rv};
                    end
                    ORD_POST: begin
                        n_slot   = {e_left, e_right, e_self};
                        n_slot_v = {tb_lv, tb_rv, 1'b1};
                    end
                    default: begin
                        n_slot   = {e_self, e_left, e_right};
                        n_slot_v = {1'b1, tb_lv, tb_rv};
                    end
                endcase
                n_j     = '0;
                n_state = ST_PUSH;
            end
            // one push per cycle through the write port, overflow ends the walk
            ST_PUSH: begin
                if (r_slot_v[r_j] && (r_sp >= CW'(NODES))) begin
                    n_state = ST_FIN;
                end else begin
                    if (r_slot_v[r_j]) begin
                        stk_we = 1'b1;
                        n_sp   = r_sp + CW'(1);
                    end
                    if (r_j == 2'd2) begin
                        n_state = ST_POP;
                    end else begin
                        n_j = r_j + 2'd1;
                    end
                end
            end
            // hold one word back so the final one can carry tlast
            ST_EMIT: begin
                if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        n_m_valid  = 1'b1;
                        n_m_node   = node_x[ID_W-1:0];
                        n_m_ord    = r_ord;
                        n_m_last   = 1'b0;
                        n_m_noroot = 1'b0;
                    end
                    n_pend_v = 1'b1;
                    n_pend   = r_ent;
                    n_k      = r_k + KW'(1);
                    n_state  = ST_POP;
                end
            end
            ST_FIN: begin
                node_x = r_pend_v ? 7'(r_pend) : 7'(r_root);
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_node   = node_x[ID_W-1:0];
                    n_m_ord    = r_ord;
                    n_m_last   = 1'b1;
                    n_m_noroot = 1'b0;
                    n_pend_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_hp      <= '0;
            r_sp      <= '0;
            r_k       <= '0;
            r_pend_v  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hp      <= n_hp;
            r_sp      <= n_sp;
            r_k       <= n_k;
            r_pend_v  <= n_pend_v;
            r_m_valid <= n_m_valid;
        end
        r_ord      <= n_ord;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_root     <= n_root;
        r_pops     <= n_pops;
        r_ent      <= n_ent;
        r_slot_v   <= n_slot_v;
        r_slot     <= n_slot;
        r_j        <= n_j;
        r_pend     <= n_pend;
        r_m_node   <= n_m_node;
        r_m_ord    <= n_m_ord;
        r_m_last   <= n_m_last;
        r_m_noroot <= n_m_noroot;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_m_ord, r_m_node};
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_noroot;

    // checks
    `BTOW_ASSERT_IMPL(a_sp_bound, i_clk, i_rst_n, 1'b1, r_sp <= CW'(NODES))
    `BTOW_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, stk_we && (r_state == ST_PUSH), r_sp < CW'(NODES))
    `BTOW_ASSERT_IMPL(a_pend_count, i_clk, i_rst_n, r_pend_v, r_k != '0)
    `BTOW_ASSERT_NEXT(a_emit_holds, i_clk, i_rst_n, (r_state == ST_EMIT) && !r_pend_v, r_pend_v)

endmodule

>>> test/tb_top.sv
// self-checking testbench for binary_tree_order_walker_top: loads trees, runs
// traversals in every order and checks each output word against a local predictor
// depends on btow_pkg and the block under test
`timescale 1ns / 1ps

module tb_top;
    import btow_pkg::*;

    localparam int NODES        = 32;
    localparam int RANDOM_WORDS = 350;
    localparam int TAIL_WORDS   = 50;
    localparam int HOLD_CYCLES  = 20;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int POP_LIMIT    = 4 * NODES + 4;

    // request and order codes that the block treats as unused
    localparam t_req   REQ_UNUSED = 2'd3;
    localparam t_order ORD_UNUSED = 2'd3;

    // one input word, or a hold marker that waits for all results
    typedef struct {
        bit          hold;
        t_req        req;
        logic [4:0]  node_id;
        logic [5:0]  left_pat;
        logic [5:0]  right_pat;
        logic [5:0]  count;
        t_order      ord;
    } t_tree_req;

    typedef struct packed {
        logic [4:0] node;
        t_order     ord;
        logic       last;
        logic       no_root;
    } t_visit_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [1:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;
    logic [0:0]           m_axis_tuser;

    binary_tree_order_walker_top #(.NODES(NODES)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_tree_req   pending_reqs[$];
    t_visit_word expected_visits[$];
    int          req_count = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    bit          word_taken = 1'b0;
    bit          tail_phase = 1'b0;

    // predictor copy of the node tables and walk stack
    logic [5:0] left_tab[NODES];
    logic [5:0] right_tab[NODES];
    bit [NODES-1:0] parent_mark = '0;
    logic [6:0] walk_stk[NODES];
    int walk_sp = 0;

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit child_ok(logic [5:0] pat);
        return !pat[5] && (int'(pat) < NODES);
    endfunction

    function automatic bit stack_push(logic [5:0] node, bit expanded);
        if (walk_sp >= NODES) return 1'b0;
        walk_stk[walk_sp] = {expanded, node};
        walk_sp++;
        return 1'b1;
    endfunction

    function automatic bit push_child(logic [5:0] pat);
        if (!child_ok(pat)) return 1'b1;
        return stack_push(pat, 1'b0);
    endfunction

    // readable form of one output word
    function automatic string fmt_word(t_visit_word w);
        return $sformatf("node %0d order %0d last %0b no_root %0b",
                         w.node, w.ord, w.last, w.no_root);
    endfunction

    // update the tree state for one accepted word and queue its visits
    task automatic apply_request(input t_req req, input logic [S_TDATA_W-1:0] d);
        logic [4:0] id;
        logic [5:0] lpat, rpat, cnt, e, node;
        t_order     walk_ord;
        int         lim, root, pops;
        bit         found, ok;
        logic [4:0] visits[$];
        id       = d[4:0];
        lpat     = d[10:5];
        rpat     = d[16:11];
        cnt      = d[22:17];
        walk_ord = d[24:23];
        found    = 1'b0;
        ok       = 1'b1;
        root     = 0;
        pops     = 0;
        case (req)
            REQ_CLEAR: parent_mark = '0;
            REQ_LOAD: begin
                if (int'(id) < NODES) begin
                    left_tab[id]  = lpat;
                    right_tab[id] = rpat;
                    if (child_ok(lpat)) parent_mark[lpat] = 1'b1;
                    if (child_ok(rpat)) parent_mark[rpat] = 1'b1;
                end
            end
            REQ_TRAVERSE: begin
                if (walk_ord == ORD_UNUSED) walk_ord = ORD_PRE;
                lim = (int'(cnt) > NODES) ? NODES : int'(cnt);
                for (int i = 0; i < lim; i++) begin
                    if (!found && !parent_mark[i]) begin
                        root  = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    expected_visits.push_back('{5'd0, walk_ord, 1'b1, 1'b1});
                end else begin
                    walk_sp = 0;
                    void'(stack_push(6'(root), 1'b0));
                    while (ok && walk_sp > 0 && visits.size() < MAX_OUT
                           && pops < POP_LIMIT) begin
                        pops++;
                        walk_sp--;
                        e    = walk_stk[walk_sp][5:0];
                        node = 6'(int'(e) % NODES);
                        if (walk_stk[walk_sp][6]) begin
                            visits.push_back(node[4:0]);
                        end else begin
                            case (walk_ord)
                                ORD_PRE: ok = push_child(right_tab[node])
                                              && push_child(left_tab[node])
                                              && stack_push(node, 1'b1);
                                ORD_IN:  ok = push_child(right_tab[node])
                                              && stack_push(node, 1'b1)
                                              && push_child(left_tab[node]);
                                default: ok = stack_push(node, 1'b1)
                                              && push_child(right_tab[node])
                                              && push_child(left_tab[node]);
                            endcase
                        end
                    end
                    // a walk cut off before any visit reports the root alone
                    if (visits.size() == 0) begin
                        expected_visits.push_back('{5'(root), walk_ord, 1'b1, 1'b0});
                    end else begin
                        foreach (visits[i]) begin
                            expected_visits.push_back('{visits[i], walk_ord,
                                                        i == visits.size() - 1, 1'b0});
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic void queue_word(t_req req, logic [4:0] id, logic [5:0] lpat,
                                       logic [5:0] rpat, logic [5:0] cnt, t_order ord);
        pending_reqs.push_back('{1'b0, req, id, lpat, rpat, cnt, ord});
        if (req != REQ_UNUSED) req_count++;
    endfunction

    function automatic void queue_hold();
        pending_reqs.push_back('{1'b1, REQ_CLEAR, 5'd0, 6'd0, 6'd0, 6'd0, ORD_PRE});
    endfunction

    // random well-formed tree on ids below n, loaded in shuffled order
    function automatic void queue_tree(int n);
        logic [5:0] tl[NODES];
        logic [5:0] tr[NODES];
        int perm[NODES];
        int j, k, tmp;
        bit placed;
        for (int i = 0; i < NODES; i++) begin
            tl[i]   = 6'h3F;
            tr[i]   = 6'h3F;
            perm[i] = i;
        end
        for (int i = n - 1; i > 0; i--) begin
            k       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[k];
            perm[k] = tmp;
        end
        // attach each node to a free slot of an earlier one, often the newest
        for (int i = 1; i < n; i++) begin
            placed = 1'b0;
            while (!placed) begin
                j = ($urandom_range(0, 2) == 0) ? i - 1 : $urandom_range(0, i - 1);
                if ($urandom_range(0, 1) == 0 && tl[perm[j]] == 6'h3F) begin
                    tl[perm[j]] = 6'(perm[i]);
                    placed      = 1'b1;
                end else if (tr[perm[j]] == 6'h3F) begin
                    tr[perm[j]] = 6'(perm[i]);
                    placed      = 1'b1;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            k = perm[(i + 1) % n];
            // now and then a load goes missing and the stale entry stays
            if ($urandom_range(0, 15) != 0) begin
                queue_word(REQ_LOAD, 5'(k), tl[k], tr[k], 6'($urandom), 2'($urandom));
            end
        end
    endfunction

    // drive the input stream on the falling edge
    always @(negedge i_clk) begin : drive_proc
        t_tree_req w;
        bit        nv;
        int        send_gap;
        int        hold_cnt;
        nv = s_axis_tvalid;
        if (!i_rst_n) begin
            nv       = 1'b0;
            send_gap = 0;
            hold_cnt = 0;
        end else begin
            if (word_taken) begin
                nv         = 1'b0;
                word_taken = 1'b0;
            end
            if (!nv) begin
                tail_phase = pending_reqs.size() <= TAIL_WORDS;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_reqs.size() > 0) begin
                    if (pending_reqs[0].hold) begin
                        // wait for every visit word, then a short quiet time
                        if (expected_visits.size() != 0) begin
                            hold_cnt = 0;
                        end else if (hold_cnt == HOLD_CYCLES) begin
                            void'(pending_reqs.pop_front());
                            hold_cnt = 0;
                        end else begin
                            hold_cnt++;
                        end
                    end else begin
                        w  = pending_reqs.pop_front();
                        nv = 1'b1;
                        s_axis_tuser <= w.req;
                        s_axis_tdata <= {{(S_TDATA_W - 25){1'b0}}, w.ord, w.count,
                                         w.right_pat, w.left_pat, w.node_id};
                        if (!tail_phase && $urandom_range(0, 3) == 0) begin
                            send_gap = $urandom_range(1, 13);
                        end
                    end
                end
            end
        end
        s_axis_tvalid <= nv;
    end

    // output backpressure in random bursts
    always @(negedge i_clk) begin : ready_proc
        int stall_left;
        if (!i_rst_n) begin
            stall_left = 0;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // sample both streams on the rising edge
    always @(posedge i_clk) begin : check_proc
        t_visit_word got, want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_request(t_req'(s_axis_tuser), s_axis_tdata);
                word_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[4:0], t_order'(m_axis_tdata[6:5]),
                        m_axis_tlast, m_axis_tuser[0]};
                if (expected_visits.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual %s",
                             $time, fmt_word(got));
                    error_count++;
                end else begin
                    want = expected_visits.pop_front();
                    if (got !== want || m_axis_tdata[7] !== 1'b0) begin
                        $display("%0t: mismatch: expected %s, actual %s fill %0b",
                                 $time, fmt_word(want), fmt_word(got), m_axis_tdata[7]);
                        error_count++;
                    end
                end
            end
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL binary_tree_order_walker_top");
        $finish;
    end

    initial begin
        int random_base, r, n, reps;
        // give every table entry a known value, all leaves
        for (int i = 0; i < NODES; i++) begin
            queue_word(REQ_LOAD, 5'(i), 6'h3F, 6'h3F, 6'd0, ORD_PRE);
        end

        // directed: no root with a zero count, unused order
        queue_word(REQ_TRAVERSE, 5'd0, 6'd0, 6'd0, 6'd0, ORD_PRE);
        queue_word(REQ_TRAVERSE, 5'd31, 6'h3F, 6'h3F, 6'd0, ORD_UNUSED);
        // small tree 0 -> (1, 2), 1 -> 3, 2 -> right 4
        queue_word(REQ_LOAD, 5'd0, 6'd1, 6'd2, 6'd0, ORD_PRE);
        queue_word(REQ_LOAD, 5'd1, 6'd3, 6'h3F, 6'd0, ORD_PRE);
        queue_word(REQ_LOAD, 5'd2, 6'h3F, 6'd4, 6'd0, ORD_PRE);
        queue_word(REQ_TRAVERSE, 5'd0, 6'd0, 6'd0, 6'd5, ORD_PRE);
        queue_word(REQ_TRAVERSE, 5'd0, 6'd0, 6'd0, 6'd5, ORD_IN);
        queue_word(REQ_TRAVERSE, 5'd0, 6'd0, 6'd0, 6'd5, ORD_POST);
        queue_word(REQ_TRAVERSE, 5'd0, 6'd0, 6'd0, 6'd5, ORD_UNUSED);
        // count saturation and the full count
        queue_word(REQ_TRAVERSE, 5'd0, 6'd0, 6'd0, 6'd63, ORD_IN);
        queue_word(REQ_TRAVERSE, 5'd0, 6'd0, 6'd0, 6'd32, ORD_POST);
        // unused request type, then odd negative children that mark nothing
        queue_word(REQ_UNUSED, 5'd2, 6'd3, 6'd4, 6'd5, ORD_IN);
        queue_word(REQ_LOAD, 5'd3, 6'h20, 6'h3B, 6'd0, ORD_PRE);
        queue_word(REQ_TRAVERSE, 5'd0, 6'd0, 6'd0, 6'd5, ORD_PRE);
        // cycle below the root: node 1 points at itself on both sides
        queue_word(REQ_CLEAR, 5'd0, 6'd0, 6'd0, 6'd0, ORD_PRE);
        queue_word(REQ_LOAD, 5'd0, 6'd1, 6'h3F, 6'd0, ORD_PRE);
        queue_word(REQ_LOAD, 5'd1, 6'd1, 6'd1, 6'd0, ORD_PRE);
        queue_word(REQ_TRAVERSE, 5'd0, 6'd0, 6'd0, 6'd2, ORD_PRE);
        queue_word(REQ_TRAVERSE, 5'd0, 6'd0, 6'd0, 6'd2, ORD_IN);
        queue_word(REQ_TRAVERSE, 5'd0, 6'd0, 6'd0, 6'd2, ORD_POST);
        // two nodes parenting each other leave no root below a count of two, while a count of three reaches node 2
        queue_word(REQ_CLEAR, 5'd0, 6'd0, 6'd0, 6'd0, ORD_PRE);
        queue_word(REQ_LOAD, 5'd0, 6'd1, 6'h3F, 6'd0, ORD_PRE);
        queue_word(REQ_LOAD, 5'd1, 6'd0, 6'h3F, 6'd0, ORD_PRE);
        queue_word(REQ_TRAVERSE, 5'd0, 6'd0, 6'd0, 6'd2, ORD_IN);
        queue_word(REQ_TRAVERSE, 5'd0, 6'd0, 6'd0, 6'd3, ORD_POST);
        queue_hold();

        // random: mostly well-formed trees, some noise words
        random_base = req_count;
        while (req_count < random_base + RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                if ($urandom_range(0, 9) != 0) begin
                    queue_word(REQ_CLEAR, 5'($urandom), 6'($urandom), 6'($urandom),
                               6'($urandom), 2'($urandom));
                end
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(11, NODES)
                                                : $urandom_range(1, 10);
                queue_tree(n);
                reps = $urandom_range(1, 3);
                for (int i = 0; i < reps; i++) begin
                    queue_word(REQ_TRAVERSE, 5'($urandom), 6'($urandom), 6'($urandom),
                               ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'(n),
                               2'($urandom));
                end
                if ($urandom_range(0, 7) == 0) queue_hold();
            end else begin
                queue_word(2'($urandom), 5'($urandom), 6'($urandom), 6'($urandom),
                           6'($urandom), 2'($urandom));
            end
        end

        // reset, then run until all words are sent and answered
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_visits.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_visits.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, expected_visits.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("PASS binary_tree_order_walker_top");
        end else begin
            $display("FAIL binary_tree_order_walker_top");
        end
        $finish;
    end

endmodule
